### rtl/seev_pkg.sv
`default_nettype none

package seev_pkg;

    // The operand base digit, then the symbol bytes with a special meaning; every other byte is an operand.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_LEFTOVER  = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;
    localparam logic [2:0] ST_BADEXP    = 3'd5;
    localparam logic [2:0] ST_PAREN     = 3'd6;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

    // Quotient bits produced by the divider, one per cycle.
    localparam int DIV_STEPS = 48;
    localparam int CNT_W     = 6;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_word_t;

    typedef enum logic [2:0] {
        SYM_OPERAND,
        SYM_PAREN,
        SYM_ADD,
        SYM_SUB,
        SYM_MUL,
        SYM_DIV,
        SYM_POW
    } sym_class_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic       done;
        logic [2:0] status;
    } alu_resp_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_READ2,
        CS_START,
        CS_WAIT,
        CS_FINISH
    } ctl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL_P,
        A_MUL_S,
        A_DIV,
        A_DIV_FIX,
        A_DONE
    } alu_state_t;

    function automatic sym_class_t classify_symbol(input logic [7:0] c);
        sym_class_t k;
        case (c)
            CH_LPAREN, CH_RPAREN: k = SYM_PAREN;
            CH_PLUS:              k = SYM_ADD;
            CH_MINUS:             k = SYM_SUB;
            CH_STAR:              k = SYM_MUL;
            CH_SLASH:             k = SYM_DIV;
            CH_CARET, CH_DOLLAR:  k = SYM_POW;
            default:              k = SYM_OPERAND;
        endcase
        return k;
    endfunction

    function automatic logic signed [31:0] sat_to_q16(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'(Q16_MAX)) begin
            r = Q16_MAX;
        end else if (v < 48'(Q16_MIN)) begin
            r = Q16_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/seev_alu.sv
`default_nettype none

module seev_alu #(
    parameter int MAX_EXPONENT = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire seev_pkg::alu_req_t req,
    input  wire logic signed [31:0] a_in,
    input  wire logic signed [31:0] b_in,
    output seev_pkg::alu_resp_t     resp,
    output logic signed [31:0]      result
);
    import seev_pkg::*;

    alu_state_t         state_reg, state_next;
    alu_op_t            op_reg, op_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] mulb_reg, mulb_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dsr_reg, dsr_next;
    logic [47:0]        dvd_reg, dvd_next;
    logic               neg_reg, neg_next;
    logic [2:0]         err_reg, err_next;

    logic [31:0] a_mag, b_mag;
    logic [14:0] exp_int;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [31:0] q_neg;

    assign a_mag   = a_in[31] ? 32'(-a_in) : 32'(a_in);
    assign b_mag   = b_in[31] ? 32'(-b_in) : 32'(b_in);
    assign exp_int = b_in[30:16];
    assign rem_sh  = {rem_reg, dvd_reg[47]};
    assign rem_ge  = rem_sh >= {1'b0, dsr_reg};
    assign q_neg   = ~dvd_reg[31:0] + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        mulb_reg <= mulb_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        dvd_reg  <= dvd_next;
        neg_reg  <= neg_next;
        err_reg  <= err_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        mulb_next  = mulb_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        dvd_next   = dvd_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    err_next = ST_OK;
                    case (req.op)
                        OP_ADD: begin
                            acc_next   = sat_to_q16(48'(a_in) + 48'(b_in));
                            state_next = A_DONE;
                        end
                        OP_SUB: begin
                            acc_next   = sat_to_q16(48'(a_in) - 48'(b_in));
                            state_next = A_DONE;
                        end
                        OP_MUL: begin
                            acc_next   = a_in;
                            mulb_next  = b_in;
                            cnt_next   = CNT_W'(1);
                            state_next = A_MUL_P;
                        end
                        OP_DIV: begin
                            if (b_in == 32'sd0) begin
                                err_next   = ST_DIVZERO;
                                state_next = A_DONE;
                            end else begin
                                neg_next   = a_in[31] ^ b_in[31];
                                dvd_next   = {a_mag, 16'h0000};
                                dsr_next   = b_mag;
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = A_DIV;
                            end
                        end
                        default: begin
                            // Power: repeated Q16 multiply by the base.
                            acc_next  = ONE_Q16;
                            mulb_next = a_in;
                            if (b_in[31] || (exp_int > 15'(MAX_EXPONENT))) begin
                                err_next   = ST_BADEXP;
                                state_next = A_DONE;
                            end else if (exp_int == 15'd0) begin
                                state_next = A_DONE;
                            end else begin
                                cnt_next   = exp_int[CNT_W-1:0];
                                state_next = A_MUL_P;
                            end
                        end
                    endcase
                end
            end
            A_MUL_P: begin
                prod_next  = acc_reg * mulb_reg;
                state_next = A_MUL_S;
            end
            A_MUL_S: begin
                // Arithmetic shift is the floor division by one Q16 unit.
                acc_next = sat_to_q16($signed(prod_reg[63:16]));
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = A_DONE;
                end else begin
                    state_next = A_MUL_P;
                end
            end
            A_DIV: begin
                rem_next = rem_ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                dvd_next = {dvd_reg[46:0], rem_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = A_DIV_FIX;
                end
            end
            A_DIV_FIX: begin
                if (neg_reg) begin
                    acc_next = (dvd_reg > 48'h0000_8000_0000) ? Q16_MIN : $signed(q_neg);
                end else begin
                    acc_next = (dvd_reg > 48'h0000_7FFF_FFFF) ? Q16_MAX
                                                               : $signed(dvd_reg[31:0]);
                end
                state_next = A_DONE;
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    assign resp.done   = (state_reg == A_DONE);
    assign resp.status = err_reg;
    assign result      = acc_reg;

endmodule

`default_nettype wire

### rtl/stack_expression_evaluator_core.sv
// An operand or parenthesis is handled as it is accepted; a word with last then emits a result.
// Operators take 2 stack reads, then the shared arithmetic unit: + and - are one saturated add,
// * a multiply and a shift, / one quotient bit per cycle, ^ that multiply per unit of exponent n.
// One word is processed at a time; throughput is set by the arithmetic unit's iterations.
// Reset (synchronous, active low) empties the stack, clears the status and prefix mode.
// The stack memory is not cleared; entries are always written before they are read.
`default_nettype none

module stack_expression_evaluator_core #(
    parameter int STACK_DEPTH  = 32,
    parameter int MAX_EXPONENT = 31
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire seev_pkg::in_word_t s_word,
    output logic               m_valid,
    input  wire logic          m_ready,
    output seev_pkg::out_word_t m_word
);
    import seev_pkg::*;

    // The top counter must hold the full depth, the address one less.
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TW = $clog2(STACK_DEPTH + 1);

    // Value stack: one write port and one registered read port.
    logic [31:0] stack_mem [STACK_DEPTH];
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [31:0] wr_data;
    logic signed [31:0] rd_data_reg;

    ctl_state_t         state_reg, state_next;
    logic [TW-1:0]      top_reg, top_next;
    logic [2:0]         sticky_reg, sticky_next;
    logic               prefix_mode_reg;
    logic               last_reg, last_next;
    alu_op_t            op_reg, op_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] bottom_reg;
    out_word_t          out_word_reg, out_word_next;
    logic               m_valid_reg, m_valid_next;

    alu_req_t           alu_req;
    alu_resp_t          alu_resp;
    logic signed [31:0] alu_a, alu_b, alu_result;

    sym_class_t         sym_class;
    logic signed [8:0]  operand_int;
    logic signed [31:0] operand_q;
    logic [TW-1:0]      top_m1, top_m2;
    logic [2:0]         final_status;

    assign sym_class   = classify_symbol(s_word.symbol);
    assign operand_int = $signed({1'b0, s_word.symbol}) - $signed({1'b0, CH_ZERO});
    assign operand_q   = {{7{operand_int[8]}}, operand_int, 16'h0000};
    assign top_m1      = top_reg - TW'(1);
    assign top_m2      = top_reg - TW'(2);

    // In postfix mode the first value popped is the right operand; in prefix mode
    // the symbols arrive reversed, so it is the left operand.
    assign alu_a = prefix_mode_reg ? first_reg   : rd_data_reg;
    assign alu_b = prefix_mode_reg ? rd_data_reg : first_reg;

    always_comb begin
        if (sticky_reg != ST_OK) begin
            final_status = sticky_reg;
        end else if (top_reg == '0) begin
            final_status = ST_UNDERFLOW;
        end else if (top_reg != TW'(1)) begin
            final_status = ST_LEFTOVER;
        end else begin
            final_status = ST_OK;
        end
    end

    seev_alu #(
        .MAX_EXPONENT(MAX_EXPONENT)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (alu_req),
        .a_in   (alu_a),
        .b_in   (alu_b),
        .resp   (alu_resp),
        .result (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Entry zero is mirrored in a register so the final value needs no extra read.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == '0)) begin
            bottom_reg <= wr_data;
        end
        last_reg     <= last_next;
        op_reg       <= op_next;
        first_reg    <= first_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= CS_IDLE;
            top_reg         <= '0;
            sticky_reg      <= ST_OK;
            prefix_mode_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                prefix_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        sticky_next   = sticky_reg;
        last_next     = last_reg;
        op_next       = op_reg;
        first_next    = first_reg;
        out_word_next = out_word_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        wr_addr       = top_reg[AW-1:0];
        wr_data       = operand_q;
        rd_en         = 1'b0;
        rd_addr       = top_m1[AW-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        s_ready       = (state_reg == CS_IDLE);

        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    last_next  = s_word.last;
                    state_next = s_word.last ? CS_FINISH : CS_IDLE;
                    // After an error, every word is skipped until the last one.
                    if (sticky_reg == ST_OK) begin
                        case (sym_class)
                            SYM_PAREN: begin
                                sticky_next = ST_PAREN;
                            end
                            SYM_OPERAND: begin
                                if (top_reg == TW'(STACK_DEPTH)) begin
                                    sticky_next = ST_OVERFLOW;
                                end else begin
                                    wr_en    = 1'b1;
                                    top_next = top_reg + TW'(1);
                                end
                            end
                            default: begin
                                if (top_reg < TW'(2)) begin
                                    sticky_next = ST_UNDERFLOW;
                                end else begin
                                    rd_en      = 1'b1;
                                    state_next = CS_READ2;
                                    case (sym_class)
                                        SYM_ADD: op_next = OP_ADD;
                                        SYM_SUB: op_next = OP_SUB;
                                        SYM_MUL: op_next = OP_MUL;
                                        SYM_DIV: op_next = OP_DIV;
                                        default: op_next = OP_POW;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
            end
            CS_READ2: begin
                // The top entry has arrived; fetch the one below it.
                first_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = top_m2[AW-1:0];
                state_next = CS_START;
            end
            CS_START: begin
                alu_req.start = 1'b1;
                state_next    = CS_WAIT;
            end
            CS_WAIT: begin
                if (alu_resp.done) begin
                    // Two values popped and one pushed: the result never overflows.
                    if (alu_resp.status != ST_OK) begin
                        sticky_next = alu_resp.status;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = top_m2[AW-1:0];
                        wr_data  = alu_result;
                        top_next = top_m1;
                    end
                    state_next = last_reg ? CS_FINISH : CS_IDLE;
                end
            end
            CS_FINISH: begin
                // Wait for the output register to be free, then clear for the next expression.
                if (!m_valid_reg || m_ready) begin
                    out_word_next.status = final_status;
                    out_word_next.value  = (final_status == ST_OK) ? bottom_reg : 32'sd0;
                    m_valid_next         = 1'b1;
                    top_next             = '0;
                    sticky_next          = ST_OK;
                    state_next           = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_word_reg;

    // The stack pointer never runs past the stack.
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // A new result only comes out of the finish step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !(m_valid_reg && !m_ready)) |-> (state_reg == CS_FINISH))
        else $error("result produced outside the finish step");

    // The arithmetic unit only answers while the controller waits for it.
    a_alu_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_resp.done |-> (state_reg == CS_WAIT))
        else $error("arithmetic result arrived while not waiting");

    // An erroneous result carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_word.status != ST_OK)) |-> (m_word.value == 32'sd0))
        else $error("error result with nonzero value");

    // Emitting a result leaves an empty stack and a clear status.
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == CS_FINISH) && (!m_valid_reg || m_ready))
            |=> ((top_reg == '0) && (sticky_reg == ST_OK)))
        else $error("state not cleared after a result");

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

// The evaluator is fed whole expressions, one symbol per word. A local copy of
// the stack machine predicts the value and status of each expression.
// Expressions are checked in both postfix and prefix order, with random gaps on
// both channels.
module testbench;
    import seev_pkg::*;

    localparam int STACK_LIMIT = 32;
    localparam int CALC_AW = $clog2(STACK_LIMIT);
    localparam int POW_LIMIT = 31;
    localparam int MAX_GAP = 16;
    localparam int TARGET_WORDS = 1400;
    localparam int PHASE_COUNT = 6;
    localparam int STALL_LIMIT = 3000;
    // The longest operation is a power with the largest exponent, and this pause
    // is well beyond its length.
    localparam int SETTLE_CYCLES = 200;
    // The mode for each phase, with phase 0 in bit 0: postfix, prefix, prefix, postfix,
    // prefix, postfix.
    localparam logic [PHASE_COUNT-1:0] PHASE_MODES = 6'b010110;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    stack_expression_evaluator_core #(
        .STACK_DEPTH (STACK_LIMIT),
        .MAX_EXPONENT(POW_LIMIT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    always #1 aclk = ~aclk;

    // The local copy of the evaluator: its value stack, the fill level, the first
    // error of the current expression and the prefix mode that was written last.
    logic signed [31:0] calc_stack [STACK_LIMIT];
    int                 calc_depth = 0;
    logic [2:0]         calc_error = ST_OK;
    logic               calc_prefix = 1'b0;

    // Results predicted but not yet seen, and words waiting to be sent.
    out_word_t   expected_results[$];
    in_word_t    pending_words[$];
    // Scratch space in which one expression is assembled before it is queued.
    logic [7:0]  expr_syms[$];

    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          next_send_gap;
    bit          send_burst = 1'b0;
    int          recv_gap = 0;
    int          next_recv_gap;
    bit          recv_burst = 1'b0;
    out_word_t   want;
    int          phase;

    // Saturates a wide intermediate result to the Q16.16 range.
    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > longint'(Q16_MAX)) begin
            return Q16_MAX;
        end
        if (v < longint'(Q16_MIN)) begin
            return Q16_MIN;
        end
        return v[31:0];
    endfunction

    // Fixed-point product: the arithmetic shift rounds toward minus infinity.
    function automatic logic signed [31:0] q16_product(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp_q16(p >>> 16);
    endfunction

    function automatic void push_calc(input logic signed [31:0] v);
        if (calc_depth >= STACK_LIMIT) begin
            calc_error = ST_OVERFLOW;
        end else begin
            calc_stack[CALC_AW'(calc_depth)] = v;
            calc_depth++;
        end
    endfunction

    // Runs one accepted word through the local evaluator. A word that carries the
    // last mark leaves a result in the expected store.
    function automatic void eval_word(input in_word_t w);
        logic signed [31:0] top1, top2, lhs, rhs, r;
        longint             n;
        int                 k;
        out_word_t          res;
        // Once an error is latched, the rest of the expression is ignored.
        if (calc_error == ST_OK) begin
            case (w.symbol)
                CH_LPAREN, CH_RPAREN: begin
                    calc_error = ST_PAREN;
                end
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_DOLLAR: begin
                    if (calc_depth < 2) begin
                        calc_error = ST_UNDERFLOW;
                    end else begin
                        top1 = calc_stack[CALC_AW'(calc_depth - 1)];
                        top2 = calc_stack[CALC_AW'(calc_depth - 2)];
                        calc_depth -= 2;
                        // In prefix order the symbols arrive reversed, so the value on
                        // top is the left operand.
                        lhs = calc_prefix ? top1 : top2;
                        rhs = calc_prefix ? top2 : top1;
                        r = ONE_Q16;
                        case (w.symbol)
                            CH_PLUS: begin
                                r = clamp_q16(longint'(lhs) + longint'(rhs));
                            end
                            CH_MINUS: begin
                                r = clamp_q16(longint'(lhs) - longint'(rhs));
                            end
                            CH_STAR: begin
                                r = q16_product(lhs, rhs);
                            end
                            CH_SLASH: begin
                                if (rhs == 0) begin
                                    calc_error = ST_DIVZERO;
                                end else begin
                                    r = clamp_q16((longint'(lhs) * longint'(ONE_Q16))
                                                  / longint'(rhs));
                                end
                            end
                            default: begin
                                // Both power symbols use the integer part of the exponent.
                                n = longint'(rhs) >>> 16;
                                if (rhs < 0 || n > POW_LIMIT) begin
                                    calc_error = ST_BADEXP;
                                end else begin
                                    for (k = 0; k < n; k++) begin
                                        r = q16_product(r, lhs);
                                    end
                                end
                            end
                        endcase
                        if (calc_error == ST_OK) begin
                            push_calc(r);
                        end
                    end
                end
                default: begin
                    push_calc(32'((longint'(w.symbol) - longint'(CH_ZERO))
                                  * longint'(ONE_Q16)));
                end
            endcase
        end
        if (w.last) begin
            res.value = '0;
            res.status = calc_error;
            if (calc_error == ST_OK) begin
                if (calc_depth == 0) begin
                    res.status = ST_UNDERFLOW;
                end else if (calc_depth > 1) begin
                    res.status = ST_LEFTOVER;
                end else begin
                    res.value = calc_stack[0];
                end
            end
            expected_results.push_back(res);
            calc_depth = 0;
            calc_error = ST_OK;
        end
    endfunction

    function automatic bit is_special(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_DOLLAR,
            CH_LPAREN, CH_RPAREN: begin
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Operands are mostly decimal digits, so that the arithmetic stays in a useful
    // range. The rest are any byte that is not an operator or a parenthesis.
    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 85) begin
            c = CH_ZERO + 8'($urandom_range(0, 9));
        end else begin
            c = 8'($urandom_range(0, 255));
            while (is_special(c)) begin
                c = 8'($urandom_range(0, 255));
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 8))
            0, 6: return CH_PLUS;
            1, 7: return CH_MINUS;
            2, 8: return CH_STAR;
            3: return CH_SLASH;
            4: return CH_CARET;
            default: return CH_DOLLAR;
        endcase
    endfunction

    // Builds a well-formed expression. The stack count never lets an operator
    // starve, and the expression reduces to one value at the end. A deep
    // expression pushes all of its operands before the first operator.
    function automatic void build_sequence(input int operands, input bit deep);
        int pushed;
        int depth;
        expr_syms.delete();
        pushed = 0;
        depth = 0;
        while (pushed < operands || depth > 1) begin
            if (depth >= 2 && (pushed == operands || (!deep && $urandom_range(0, 99) < 40)))
            begin
                expr_syms.push_back(pick_operator());
                depth--;
            end else begin
                expr_syms.push_back(pick_operand());
                pushed++;
                depth++;
            end
        end
    endfunction

    // Queues the assembled expression. Its final symbol carries the last mark.
    function automatic void emit_syms();
        in_word_t w;
        int       i;
        for (i = 0; i < expr_syms.size(); i++) begin
            w.symbol = expr_syms[i];
            w.last = (i == expr_syms.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    function automatic void queue_text(input string s);
        int i;
        expr_syms.delete();
        for (i = 0; i < s.len(); i++) begin
            expr_syms.push_back(s[i]);
        end
        emit_syms();
    endfunction

    // A mix of expressions. Most are well formed with random content. A few are
    // deep, with operand counts near, at or past the stack depth. Some are damaged on
    // purpose, and some are random bytes.
    function automatic void fill_random(input int words);
        int count;
        int kind;
        count = 0;
        while (count < words) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                build_sequence($urandom_range(30, 33), 1'b1);
            end else if (kind < 80) begin
                build_sequence($urandom_range(1, 8), 1'b0);
            end else if (kind < 90) begin
                build_sequence($urandom_range(2, 6), 1'b0);
                case ($urandom_range(0, 2))
                    0: expr_syms.pop_back();
                    1: expr_syms.push_back(pick_operator());
                    default: expr_syms.insert($urandom_range(0, expr_syms.size() - 1),
                                              $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
                endcase
            end else begin
                expr_syms.delete();
                repeat ($urandom_range(1, 6)) begin
                    expr_syms.push_back(8'($urandom_range(0, 255)));
                end
            end
            emit_syms();
            count += expr_syms.size();
        end
    endfunction

    // Input driver. Each word is predicted as it is accepted. After every word,
    // a gap is drawn before the next one. Now and then the driver switches into
    // a burst, in which the gaps are zero.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && s_ready) begin
            eval_word(s_word);
            if ($urandom_range(0, 49) == 0) begin
                send_burst = !send_burst;
            end
            next_send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (next_send_gap == 0 && pending_words.size() != 0) begin
                s_word <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
                send_gap <= (next_send_gap > 0) ? next_send_gap - 1 : 0;
            end
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0) begin
                s_valid <= 1'b1;
                s_word <= pending_words.pop_front();
            end
        end
    end

    // Result monitor. Each accepted result is checked against the oldest
    // prediction. After that, ready may be dropped for a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, value %h status %0d",
                         $time, m_word.value, m_word.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_word.value !== want.value) begin
                    $display("%0t: value mismatch, expected %h got %h",
                             $time, want.value, m_word.value);
                    mismatch_count++;
                end
                if (m_word.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d got %0d",
                             $time, want.status, m_word.status);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 49) == 0) begin
                recv_burst = !recv_burst;
            end
            next_recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (next_recv_gap != 0) begin
                m_ready <= 1'b0;
                recv_gap <= next_recv_gap - 1;
            end
        end else if (!m_ready) begin
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: the run fails if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus. Each phase writes the mode register while the evaluator is idle
    // and then queues its expressions. It waits for every result and lets the
    // evaluator settle before the next phase. Queue work is done on the falling
    // edge so that it never races with the driver.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= PHASE_MODES[3'(phase)];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            calc_prefix = PHASE_MODES[3'(phase)];
            @(negedge aclk);
            if (phase == 0) begin
                // An operator on an empty stack, a lone parenthesis, and the largest
                // byte as an operand.
                queue_text("+");
                queue_text("(");
                expr_syms.delete();
                expr_syms.push_back(8'hFF);
                emit_syms();
                // Leftover operands, then minus, divide and both power symbols on well-behaved values.
                queue_text("12");
                queue_text("95-4/");
                queue_text("23^2$");
                // Divide by zero, with the symbols that follow ignored.
                queue_text("50/3+");
                // A negative exponent.
                queue_text("209-^");
            end
            fill_random(TARGET_WORDS / PHASE_COUNT);
            while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            begin
                @(negedge aclk);
            end
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
